>>> hw/rtl/ipfb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfb_pkg
// Shared types, flag positions and channel helpers for the icon pixel
// filter and overlay blend pipeline.
// ----------------------------------------------------------------------------
package ipfb_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned FLAGS_W   = 4;
    localparam int unsigned SUM_W     = 2 * CHAN_W;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

    // filter_flags bit positions
    localparam int unsigned FLAG_HALF   = 0;
    localparam int unsigned FLAG_GRAY   = 1;
    localparam int unsigned FLAG_TRED   = 2;
    localparam int unsigned FLAG_TGREEN = 3;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgba_t;

    // Filtered base pixel, overlay pixel and the effective blend weight
    typedef struct packed {
        rgba_t             base;
        rgba_t             over;
        logic [CHAN_W-1:0] weight;
    } mix_req_t;

    // Undivided blend sums, one per channel
    typedef struct packed {
        logic [SUM_W-1:0] alpha;
        logic [SUM_W-1:0] blue;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] red;
    } mix_sum_t;

    // c * 5 / 4, saturated at full scale
    function automatic logic [CHAN_W-1:0] up_scale(input logic [CHAN_W-1:0] c);
        logic [CHAN_W:0] v;
        v = {1'b0, c} + {3'b000, c[CHAN_W-1:2]};
        return v[CHAN_W] ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

    // c * 3 / 4, truncating
    function automatic logic [CHAN_W-1:0] down_scale(input logic [CHAN_W-1:0] c);
        logic [CHAN_W+1:0] v;
        v = {2'b00, c} + {1'b0, c, 1'b0};
        return v[CHAN_W+1:2];
    endfunction

endpackage : ipfb_pkg
`default_nettype wire

>>> hw/rtl/ipfb_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfb_filter
// Stage 1: applies half opaque, gray out, tint red and tint green in that
// order and works out the blend weight (zero when no overlay blends).
// ----------------------------------------------------------------------------
module ipfb_filter
    import ipfb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [FLAGS_W-1:0] flags,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire rgba_t              in_base,
    input  wire rgba_t              in_over,
    input  wire logic               in_present,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output mix_req_t                out_req
);

    logic     valid_reg;
    mix_req_t req_reg;
    mix_req_t req_next;

    assign in_ready = !valid_reg || out_ready;

    // Filter chain
    always_comb
    begin
        rgba_t p;
        p = in_base;
        if (flags[FLAG_HALF])
        begin
            p.alpha = {1'b0, p.alpha[CHAN_W-1:1]};
        end
        if (flags[FLAG_GRAY])
        begin
            p.red  = p.green;
            p.blue = p.green;
        end
        if (flags[FLAG_TRED])
        begin
            p.red   = up_scale(p.red);
            p.green = down_scale(p.green);
            p.blue  = down_scale(p.blue);
        end
        if (flags[FLAG_TGREEN])
        begin
            p.red   = down_scale(p.red);
            p.green = up_scale(p.green);
            p.blue  = down_scale(p.blue);
        end
        req_next.base   = p;
        req_next.over   = in_over;
        // zero weight makes the blend an exact pass-through
        req_next.weight = in_present ? in_over.alpha : '0;
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            req_reg <= req_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_req   = req_reg;

endmodule : ipfb_filter
`default_nettype wire

>>> hw/rtl/ipfb_mix_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfb_mix_mul
// Stage 2: forms o*w + d*(255-w) for each channel; the alpha channel uses
// the overlay alpha as its overlay value.
// ----------------------------------------------------------------------------
module ipfb_mix_mul
    import ipfb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mix_req_t in_req,
    output logic          out_valid,
    input  wire logic     out_ready,
    output mix_sum_t      out_sum
);

    logic     valid_reg;
    mix_sum_t sum_reg;
    mix_sum_t sum_next;

    assign in_ready = !valid_reg || out_ready;

    function automatic logic [SUM_W-1:0] mix_sum(
        input logic [CHAN_W-1:0] o,
        input logic [CHAN_W-1:0] d,
        input logic [CHAN_W-1:0] w
    );
        logic [SUM_W-1:0] po;
        logic [SUM_W-1:0] pd;
        po = {{CHAN_W{1'b0}}, o} * {{CHAN_W{1'b0}}, w};
        pd = {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, CHAN_MAX - w};
        // bounded by 255*255, no carry out
        return po + pd;
    endfunction

    // Per-channel products
    always_comb
    begin
        sum_next.red   = mix_sum(in_req.over.red,   in_req.base.red,   in_req.weight);
        sum_next.green = mix_sum(in_req.over.green, in_req.base.green, in_req.weight);
        sum_next.blue  = mix_sum(in_req.over.blue,  in_req.base.blue,  in_req.weight);
        sum_next.alpha = mix_sum(in_req.over.alpha, in_req.base.alpha, in_req.weight);
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            sum_reg <= sum_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_sum   = sum_reg;

endmodule : ipfb_mix_mul
`default_nettype wire

>>> hw/rtl/ipfb_div255.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipfb_div255
// Stage 3: divides each blend sum by 255 and holds the result pixel as the
// output register.
// ----------------------------------------------------------------------------
module ipfb_div255
    import ipfb_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire mix_sum_t in_sum,
    output logic          out_valid,
    input  wire logic     out_ready,
    output rgba_t         out_pix
);

    logic  valid_reg;
    rgba_t pix_reg;
    rgba_t pix_next;

    assign in_ready = !valid_reg || out_ready;

    // x / 255 == (x + (x >> 8) + 1) >> 8, exact for x up to 255*255
    function automatic logic [CHAN_W-1:0] div255(input logic [SUM_W-1:0] x);
        logic [SUM_W:0] t;
        t = {1'b0, x} + {{(CHAN_W+1){1'b0}}, x[SUM_W-1:CHAN_W]} + {{SUM_W{1'b0}}, 1'b1};
        return t[SUM_W-1:CHAN_W];
    endfunction

    always_comb
    begin
        pix_next.red   = div255(in_sum.red);
        pix_next.green = div255(in_sum.green);
        pix_next.blue  = div255(in_sum.blue);
        pix_next.alpha = div255(in_sum.alpha);
    end

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            pix_reg <= pix_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pix   = pix_reg;

endmodule : ipfb_div255
`default_nettype wire

>>> hw/rtl/icon_pixel_filter_blend_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// icon_pixel_filter_blend_top
// Per-pixel icon filter (half opaque, gray, tint red, tint green) followed by
// an overlay alpha blend, as a three-stage stream pipeline.
// ----------------------------------------------------------------------------
//  channel   direction  width  contents
//  s_axis    in         64+1   base RGBA, overlay RGBA; tuser overlay_present
//  m_axis    out        32     processed RGBA
//  cfg       in         4      filter_flags write
//
//  One pixel per clock sustained while m_axis accepts; three register stages
//  (filter, multiply, divide by 255) lie between an input transaction and its
//  result.
//  rst_n clears the stage valid bits and filter_flags.
//  A stall on m_axis holds the stages backed up behind it; each stage takes
//  new data only when it is empty or its data moves on in the same cycle.
// ----------------------------------------------------------------------------
module icon_pixel_filter_blend_top
    import ipfb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [FLAGS_W-1:0] cfg_wr_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // tdata: base_red, base_green, base_blue, base_alpha,
    //        over_red, over_green, over_blue, over_alpha
    input  wire logic [63:0]        s_axis_tdata,
    // tuser: overlay_present
    input  wire logic               s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // tdata: out_red, out_green, out_blue, out_alpha
    output logic [31:0]             m_axis_tdata
);

    logic [FLAGS_W-1:0] flags_reg;

    rgba_t    base;
    rgba_t    over;
    logic     s1_valid;
    logic     s1_ready;
    mix_req_t s1_req;
    logic     s2_valid;
    logic     s2_ready;
    mix_sum_t s2_sum;
    rgba_t    out_pix;

    // Filter flag register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            flags_reg <= cfg_wr_data;
        end
    end

    // Unpack input transaction
    assign base.red    = s_axis_tdata[7:0];
    assign base.green  = s_axis_tdata[15:8];
    assign base.blue   = s_axis_tdata[23:16];
    assign base.alpha  = s_axis_tdata[31:24];
    assign over.red    = s_axis_tdata[39:32];
    assign over.green  = s_axis_tdata[47:40];
    assign over.blue   = s_axis_tdata[55:48];
    assign over.alpha  = s_axis_tdata[63:56];

    ipfb_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .flags      (flags_reg),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_base    (base),
        .in_over    (over),
        .in_present (s_axis_tuser),
        .out_valid  (s1_valid),
        .out_ready  (s1_ready),
        .out_req    (s1_req)
    );

    ipfb_mix_mul u_mix_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid),
        .in_ready  (s1_ready),
        .in_req    (s1_req),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_sum   (s2_sum)
    );

    ipfb_div255 u_div255 (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_sum    (s2_sum),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_pix   (out_pix)
    );

    // Pack output transaction
    assign m_axis_tdata = {out_pix.alpha, out_pix.blue, out_pix.green, out_pix.red};

endmodule : icon_pixel_filter_blend_top
`default_nettype wire

>>> sim/pixel_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pixel_result_checker
// Watches the pixel input, result and filter-flag channels of the icon pixel
// filter/blend block. It computes the expected processed pixel for every
// accepted input transaction and compares each result transaction against
// the oldest pending one, channel by channel.
// ----------------------------------------------------------------------------
module pixel_result_checker
    import ipfb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_wr_en,
    input  wire logic [FLAGS_W-1:0] cfg_wr_data,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic [63:0]        s_axis_tdata,
    input  wire logic               s_axis_tuser,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [31:0]        m_axis_tdata,
    output int unsigned             error_count,
    output int unsigned             outstanding,
    output int unsigned             pixels_checked
);

    logic [FLAGS_W-1:0] flags_model;
    rgba_t              expected_pixels[$];
    rgba_t              pred_pixel;
    rgba_t              got_pixel;
    rgba_t              want_pixel;

    // c * 5 / 4, clipped to full scale
    function automatic int unsigned boost(input int unsigned c);
        int unsigned v;
        v = (c * 5) / 4;
        return (v > 255) ? 255 : v;
    endfunction

    // c * 3 / 4, truncating
    function automatic int unsigned dim(input int unsigned c);
        return (c * 3) / 4;
    endfunction

    // one channel of the overlay blend, truncating
    function automatic int unsigned blend_chan(input int unsigned o, input int unsigned d,
                                               input int unsigned a);
        return (o * a + d * (255 - a)) / 255;
    endfunction

    // Filters in fixed order, then the optional overlay blend
    function automatic rgba_t filter_and_blend(input rgba_t base, input rgba_t over,
                                               input logic present,
                                               input logic [FLAGS_W-1:0] flags);
        int unsigned r;
        int unsigned g;
        int unsigned b;
        int unsigned a;
        rgba_t       res;
        r = base.red;
        g = base.green;
        b = base.blue;
        a = base.alpha;
        if (flags[FLAG_HALF])
            a = a / 2;
        if (flags[FLAG_GRAY])
        begin
            r = g;
            b = g;
        end
        if (flags[FLAG_TRED])
        begin
            r = boost(r);
            g = dim(g);
            b = dim(b);
        end
        if (flags[FLAG_TGREEN])
        begin
            r = dim(r);
            g = boost(g);
            b = dim(b);
        end
        if (present && over.alpha != 0)
        begin
            r = blend_chan(over.red,   r, over.alpha);
            g = blend_chan(over.green, g, over.alpha);
            b = blend_chan(over.blue,  b, over.alpha);
            a = blend_chan(over.alpha, a, over.alpha);
        end
        res.red   = r[7:0];
        res.green = g[7:0];
        res.blue  = b[7:0];
        res.alpha = a[7:0];
        return res;
    endfunction

    task automatic check_chan(input string name, input logic [7:0] want, input logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    // Track flags, queue predictions, compare results
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_model = '0;
            expected_pixels.delete();
            error_count = 0;
            outstanding = 0;
            pixels_checked = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                pred_pixel = filter_and_blend(rgba_t'(s_axis_tdata[31:0]),
                                              rgba_t'(s_axis_tdata[63:32]),
                                              s_axis_tuser, flags_model);
                expected_pixels = {expected_pixels, pred_pixel};
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_pixel = rgba_t'(m_axis_tdata);
                if (expected_pixels.size() == 0)
                begin
                    $error("result transaction %h with no pixel pending", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want_pixel = expected_pixels.pop_front();
                    check_chan("out_red",   want_pixel.red,   got_pixel.red);
                    check_chan("out_green", want_pixel.green, got_pixel.green);
                    check_chan("out_blue",  want_pixel.blue,  got_pixel.blue);
                    check_chan("out_alpha", want_pixel.alpha, got_pixel.alpha);
                    pixels_checked++;
                end
            end
            // new flags apply from the next accepted pixel on
            if (cfg_wr_en)
                flags_model = cfg_wr_data;
            outstanding = expected_pixels.size();
        end
    end

endmodule : pixel_result_checker

>>> sim/icon_pixel_filter_blend_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// icon_pixel_filter_blend_top_test
// Drives pixel streams through the icon filter/blend block under a series of
// filter settings: a directed set of edge-case pixels first, then random
// pixels with random idle bursts on both stream sides and one long output
// hold-off. Checking is done by pixel_result_checker.
// ----------------------------------------------------------------------------
module icon_pixel_filter_blend_top_test
    import ipfb_pkg::*;
();

    localparam int unsigned CYCLE_LIMIT     = 400000;
    localparam int unsigned NUM_PHASES      = 12;
    localparam int unsigned PHASE_PIXELS    = 150;
    localparam int unsigned HOLD_OFF_CYCLES = 300;

    localparam logic [FLAGS_W-1:0] NO_FILTER   = '0;
    localparam logic [FLAGS_W-1:0] HALF_OPAQUE = FLAGS_W'(1 << FLAG_HALF);
    localparam logic [FLAGS_W-1:0] GRAY_OUT    = FLAGS_W'(1 << FLAG_GRAY);
    localparam logic [FLAGS_W-1:0] TINT_RED    = FLAGS_W'(1 << FLAG_TRED);
    localparam logic [FLAGS_W-1:0] TINT_GREEN  = FLAGS_W'(1 << FLAG_TGREEN);
    localparam logic [FLAGS_W-1:0] ALL_FILTERS = HALF_OPAQUE | GRAY_OUT | TINT_RED | TINT_GREEN;

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [FLAGS_W-1:0] cfg_wr_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    // tdata: base_red, base_green, base_blue, base_alpha,
    //        over_red, over_green, over_blue, over_alpha
    logic [63:0]        s_axis_tdata;
    // tuser: overlay_present
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    // tdata: out_red, out_green, out_blue, out_alpha
    logic [31:0]        m_axis_tdata;

    int unsigned error_count;
    int unsigned outstanding;
    int unsigned pixels_checked;
    int unsigned cycle_count;
    int unsigned pixels_sent;
    int unsigned pixels_blended;
    int unsigned settings_used;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;
    bit          hold_off_request;

    icon_pixel_filter_blend_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    pixel_result_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tuser   (s_axis_tuser),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .error_count    (error_count),
        .outstanding    (outstanding),
        .pixels_checked (pixels_checked)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Run limit
    initial cycle_count = 0;
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d pixels still pending",
                     cycle_count, outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random stall bursts plus one long hold-off on request
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_request)
            begin
                hold_off_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else if (sink_idle_pct != 0 && $urandom_range(0, 99) < sink_idle_pct)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 18)) @(posedge clk);
                m_axis_tready <= 1'b1;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic rgba_t pix(input logic [7:0] r, input logic [7:0] g,
                                  input logic [7:0] b, input logic [7:0] a);
        return {a, b, g, r};
    endfunction

    // Channel value biased toward the extremes
    function automatic logic [7:0] rand_chan();
        int unsigned sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // Offer one pixel, optionally after an idle burst, and wait for acceptance
    task automatic send_pixel(input rgba_t base, input rgba_t over, input logic present);
        if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {over, base};
        s_axis_tuser  <= present;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pixels_sent++;
        if (present && over.alpha != 0)
            pixels_blended++;
    endtask

    // Stop offering and wait until every pixel has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic set_filter_flags(input logic [FLAGS_W-1:0] flags);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= flags;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        settings_used++;
    endtask

    // Edge cases: extremes, ignored overlays, opaque and faint overlays,
    // tint saturation thresholds, alternating bit patterns
    task automatic send_edge_pixels();
        send_pixel(pix(0, 0, 0, 0), pix(0, 0, 0, 0), 1'b0);
        send_pixel(pix(255, 255, 255, 255), pix(0, 0, 0, 0), 1'b0);
        send_pixel(pix(255, 0, 255, 255), pix(255, 255, 255, 0), 1'b1);
        send_pixel(pix(200, 100, 50, 128), pix(10, 20, 30, 255), 1'b1);
        send_pixel(pix(0, 0, 0, 0), pix(255, 255, 255, 1), 1'b1);
        send_pixel(pix(255, 255, 255, 255), pix(0, 0, 0, 254), 1'b1);
        send_pixel(pix(1, 2, 3, 1), pix(255, 255, 255, 255), 1'b0);
        send_pixel(pix(204, 205, 51, 255), pix(0, 0, 0, 0), 1'b0);
        send_pixel(pix(255, 128, 3, 3), pix(128, 64, 32, 128), 1'b1);
        send_pixel(pix(8'h55, 8'hAA, 8'h55, 8'hAA), pix(8'hAA, 8'h55, 8'hAA, 8'h55), 1'b1);
        send_pixel(pix(8'hAA, 8'h55, 8'hAA, 8'h55), pix(8'h55, 8'hAA, 8'h55, 8'hAA), 1'b1);
        send_pixel(pix(3, 1, 2, 1), pix(255, 255, 255, 255), 1'b1);
    endtask

    task automatic send_random_pixels(input int unsigned count);
        rgba_t       base;
        rgba_t       over;
        logic        present;
        int unsigned sel;
        repeat (count)
        begin
            base = pix(rand_chan(), rand_chan(), rand_chan(), rand_chan());
            over = pix(rand_chan(), rand_chan(), rand_chan(), rand_chan());
            sel = $urandom_range(0, 5);
            if (sel == 0)
                over.alpha = 8'h00;
            else if (sel == 1)
                over.alpha = 8'hFF;
            present = ($urandom_range(0, 3) != 0);
            send_pixel(base, over, present);
        end
    endtask

    // Stimulus
    initial
    begin
        logic [FLAGS_W-1:0] phase_flags[NUM_PHASES];
        phase_flags = '{NO_FILTER, ALL_FILTERS, HALF_OPAQUE, GRAY_OUT, TINT_RED, TINT_GREEN,
                        TINT_RED | TINT_GREEN, HALF_OPAQUE | GRAY_OUT, GRAY_OUT | TINT_RED,
                        HALF_OPAQUE | TINT_GREEN, NO_FILTER, NO_FILTER};
        rst_n            = 1'b0;
        cfg_wr_en        = 1'b0;
        cfg_wr_data      = '0;
        s_axis_tvalid    = 1'b0;
        s_axis_tdata     = '0;
        s_axis_tuser     = 1'b0;
        hold_off_request = 1'b0;
        src_idle_pct     = 0;
        sink_idle_pct    = 0;
        pixels_sent      = 0;
        pixels_blended   = 0;
        settings_used    = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed pixels with filters off, then with all filters on
        set_filter_flags(NO_FILTER);
        send_edge_pixels();
        wait_drained();
        src_idle_pct  = 10;
        sink_idle_pct = 5;
        set_filter_flags(ALL_FILTERS);
        send_edge_pixels();
        wait_drained();

        // random phases, one filter setting each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p >= 10)
                phase_flags[p] = FLAGS_W'($urandom_range(0, 15));
            case ($urandom_range(0, 3))
                0: src_idle_pct = 0;
                1: src_idle_pct = 3;
                2: src_idle_pct = 10;
                default: src_idle_pct = 25;
            endcase
            case ($urandom_range(0, 3))
                0: sink_idle_pct = 0;
                1: sink_idle_pct = 2;
                2: sink_idle_pct = 5;
                default: sink_idle_pct = 12;
            endcase
            // closing phase runs at full rate on both sides
            if (p == NUM_PHASES - 1)
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            set_filter_flags(phase_flags[p]);
            if (p == 3)
            begin
                src_idle_pct     = 0;
                hold_off_request = 1'b1;
            end
            send_random_pixels(PHASE_PIXELS);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("Sent %0d pixels (%0d with an active overlay) under %0d filter settings,",
                 pixels_sent, pixels_blended, settings_used);
        $display("%0d results compared, including a %0d-cycle output hold-off.",
                 pixels_checked, HOLD_OFF_CYCLES);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule : icon_pixel_filter_blend_top_test
